### hdl/keyed_statistics_counter_table_macros.svh
// ---------------------------------------------------------------------------
// Keyed statistics counter table: assertion macros
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef KEYED_STATISTICS_COUNTER_TABLE_MACROS_SVH
`define KEYED_STATISTICS_COUNTER_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/kst_pkg.sv
// ---------------------------------------------------------------------------
// Keyed statistics counter table: package
// Request and response payloads, operation and status codes, FSM states.
// ---------------------------------------------------------------------------
package kst_pkg;

  typedef enum logic [2:0] {
    OP_SUBSCRIBE   = 3'd0,
    OP_UNSUBSCRIBE = 3'd1,
    OP_INCREMENT   = 3'd2,
    OP_ADD         = 3'd3,
    OP_SET         = 3'd4,
    OP_READ        = 3'd5,
    OP_RESET_COUNT = 3'd6,
    OP_CHECK_DIRTY = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    RS_OK         = 3'd0,
    RS_INVALID_ID = 3'd1,
    RS_ALREADY    = 3'd2,
    RS_NO_SLOT    = 3'd3,
    RS_NOT_FOUND  = 3'd4,
    RS_NOT_DIRTY  = 3'd5
  } status_t;

  localparam int unsigned ACTIVE_OUT_W = 5;
  localparam int unsigned ACTIVE_MAX   = 31;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] stat_id;
    logic [31:0] operand;
  } kst_req_t;

  typedef struct packed {
    status_t                   status;
    logic [31:0]               read_value;
    logic                      notify;
    logic [ACTIVE_OUT_W-1:0]   active_count;
  } kst_rsp_t;

  // Lookup outcome handed from the key scanner to the control FSM.
  typedef struct packed {
    logic done;        // one-cycle pulse, flags below are final
    logic found;       // an in-use slot holds the key
    logic free_found;  // at least one slot is free
  } kst_scan_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_UPDATE
  } fsm_t;

endpackage

### hdl/kst_stream_if.sv
// ---------------------------------------------------------------------------
// Keyed statistics counter table: stream interface
// Valid/ready channel carrying one payload per transfer.
// ---------------------------------------------------------------------------
interface kst_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hdl/keyed_statistics_counter_table.sv
// ---------------------------------------------------------------------------
// Keyed statistics counter table: top level
// Slot table of statistic identifiers and 32-bit counters with subscribe,
// unsubscribe, update, read and dirty-check requests.
// ---------------------------------------------------------------------------
//
//  channel | dir | payload                                   | transfer when
//  --------+-----+-------------------------------------------+----------------
//  req     | in  | kind, stat_id, operand                    | valid && ready
//  rsp     | out | status, read_value, notify, active_count  | valid && ready
//
//  One request in flight at a time; each request takes a walk over the key
//  memory, one entry per cycle, then one counter read and one write-back.
//  Response sits in an output register: the next request is taken while it
//  waits; the write-back stalls only if the previous response is still held.
//  Reset clears the in-use and dirty flags and the active count; memory
//  contents of free slots are never observed, so no clearing pass.
//
`include "keyed_statistics_counter_table_macros.svh"

module keyed_statistics_counter_table #(
  parameter int unsigned SLOTS = 16
) (
  input logic         clk,
  input logic         rst,
  kst_stream_if.sink   req,
  kst_stream_if.source rsp
);
  import kst_pkg::*;

  localparam int unsigned IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned ACTW = $clog2(SLOTS + 1);

  // control state
  fsm_t            state, state_next;
  kst_req_t        req_q;            // captured request
  logic [SLOTS-1:0] in_use;
  logic [SLOTS-1:0] changed;         // dirty marks
  logic [ACTW-1:0] active;
  logic            rsp_valid;
  kst_rsp_t        rsp_q;

  // scanner handshake
  logic            scan_start;
  kst_scan_t       scan;
  logic [IDXW-1:0] hit_idx;
  logic [IDXW-1:0] free_idx;

  // counter memory
  logic [31:0]     cnt_mem [SLOTS];
  logic [31:0]     cnt_rd;
  logic            fetch_en;

  // write-back decode
  logic            commit;
  status_t         status_c;
  logic [31:0]     value_c;
  logic            notify_c;
  logic            key_we;
  logic            cnt_we;
  logic [IDXW-1:0] cnt_waddr;
  logic [31:0]     cnt_wdata;
  logic            use_set, use_clr;
  logic            chg_set, chg_clr;
  logic [IDXW-1:0] chg_addr;
  logic [ACTW-1:0] active_next;
  logic [ACTIVE_OUT_W-1:0] active_sat;

  kst_key_scan #(
    .SLOTS (SLOTS),
    .IDXW  (IDXW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .id        (req_q.stat_id),
    .in_use    (in_use),
    .key_wr    (commit && key_we),
    .key_waddr (free_idx),
    .key_wdata (req_q.stat_id),
    .scan      (scan),
    .hit_idx   (hit_idx),
    .free_idx  (free_idx)
  );

  // --- sequencer -----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req.valid) state_next = S_SCAN;
      S_SCAN:   if (scan.done) state_next = S_FETCH;
      S_FETCH:  state_next = S_UPDATE;
      S_UPDATE: if (!rsp_valid || rsp.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready  = (state == S_IDLE);
    scan_start = (state == S_IDLE) && req.valid;
    fetch_en   = (state == S_FETCH);
    // write-back waits for a free output register
    commit     = (state == S_UPDATE) && (!rsp_valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      req_q <= req.payload;
    end
  end

  // --- counter memory: read the matched slot, write back on commit --------
  // Writes land before the next request is taken, so a scan or fetch never
  // overlaps a write to the same entry.
  always_ff @(posedge clk) begin
    if (fetch_en) begin
      cnt_rd <= cnt_mem[hit_idx];
    end
    if (commit && cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  // --- request decode ------------------------------------------------------
  always_comb begin
    status_c    = RS_OK;
    value_c     = '0;
    notify_c    = 1'b0;
    key_we      = 1'b0;
    cnt_we      = 1'b0;
    cnt_waddr   = hit_idx;
    cnt_wdata   = '0;
    use_set     = 1'b0;
    use_clr     = 1'b0;
    chg_set     = 1'b0;
    chg_clr     = 1'b0;
    chg_addr    = hit_idx;
    active_next = active;
    unique case (req_q.kind)
      OP_SUBSCRIBE: begin
        priority if (req_q.stat_id == '0) begin
          status_c = RS_INVALID_ID;
        end else if (scan.found) begin
          status_c = RS_ALREADY;
        end else if (!scan.free_found) begin
          status_c = RS_NO_SLOT;
        end else begin
          // claim lowest free slot with a fresh counter
          key_we      = 1'b1;
          cnt_we      = 1'b1;
          cnt_waddr   = free_idx;
          use_set     = 1'b1;
          chg_clr     = 1'b1;
          chg_addr    = free_idx;
          active_next = active + ACTW'(1);
        end
      end
      OP_UNSUBSCRIBE: begin
        if (!scan.found) begin
          status_c = RS_NOT_FOUND;
        end else begin
          cnt_we      = 1'b1;
          use_clr     = 1'b1;
          chg_clr     = 1'b1;
          active_next = active - ACTW'(1);
        end
      end
      OP_INCREMENT: begin
        if (!scan.found) begin
          status_c = RS_NOT_FOUND;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rd + 32'd1;
          chg_set   = 1'b1;
          notify_c  = 1'b1;
        end
      end
      OP_ADD: begin
        if (!scan.found) begin
          status_c = RS_NOT_FOUND;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rd + req_q.operand;
          chg_set   = 1'b1;
          notify_c  = 1'b1;
        end
      end
      OP_SET: begin
        if (!scan.found) begin
          status_c = RS_NOT_FOUND;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = req_q.operand;
          chg_set   = 1'b1;
          notify_c  = 1'b1;
        end
      end
      OP_READ: begin
        if (!scan.found) begin
          status_c = RS_NOT_FOUND;
        end else begin
          value_c = cnt_rd;
        end
      end
      OP_RESET_COUNT: begin
        // dirty mark is left alone
        if (!scan.found) begin
          status_c = RS_NOT_FOUND;
        end else begin
          cnt_we = 1'b1;
        end
      end
      OP_CHECK_DIRTY: begin
        priority if (!scan.found) begin
          status_c = RS_NOT_FOUND;
        end else if (!changed[hit_idx]) begin
          status_c = RS_NOT_DIRTY;
        end else begin
          chg_clr = 1'b1;
          value_c = cnt_rd;
        end
      end
      default: status_c = RS_OK;
    endcase
    // active count saturates on the narrow response field
    active_sat = (32'(active_next) > 32'(ACTIVE_MAX)) ?
                 ACTIVE_OUT_W'(ACTIVE_MAX) : ACTIVE_OUT_W'(active_next);
  end

  // --- slot flags and active count ------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use  <= '0;
      changed <= '0;
      active  <= '0;
    end else if (commit) begin
      if (use_set) in_use[free_idx] <= 1'b1;
      if (use_clr) in_use[hit_idx]  <= 1'b0;
      if (chg_set) changed[chg_addr] <= 1'b1;
      if (chg_clr) changed[chg_addr] <= 1'b0;
      active <= active_next;
    end
  end

  // --- response register ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp_q.status       <= status_c;
      rsp_q.read_value   <= value_c;
      rsp_q.notify       <= notify_c;
      rsp_q.active_count <= active_sat;
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_q;

  // --- checks ---------------------------------------------------------------
  `KST_ASSERT_SAME(a_active_tracks_flags, clk, rst, 1'b1, 32'(active) == 32'($countones(in_use)), "active count disagrees with in-use flags")
  `KST_ASSERT_SAME(a_claim_free_slot, clk, rst, commit && key_we, !in_use[free_idx], "subscribe claims a slot already in use")
  `KST_ASSERT_SAME(a_scan_done_in_scan, clk, rst, scan.done, state == S_SCAN, "scan finished outside the scan state")
  `KST_ASSERT_NEXT(a_notify_only_ok, clk, rst, commit && notify_c, rsp_valid && rsp_q.status == RS_OK, "notify on a failed request")

endmodule

### hdl/kst_key_scan.sv
// ---------------------------------------------------------------------------
// Keyed statistics counter table: key scanner
// Key memory plus a sequential walk that finds the lowest matching slot
// and the lowest free slot, one entry per cycle.
// ---------------------------------------------------------------------------
module kst_key_scan #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned IDXW  = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          id,
  input  logic [SLOTS-1:0]     in_use,
  input  logic                 key_wr,
  input  logic [IDXW-1:0]      key_waddr,
  input  logic [31:0]          key_wdata,
  output kst_pkg::kst_scan_t   scan,
  output logic [IDXW-1:0]      hit_idx,
  output logic [IDXW-1:0]      free_idx
);
  import kst_pkg::*;

  localparam logic [IDXW-1:0] LAST = IDXW'(SLOTS - 1);

  logic [31:0]     key_mem [SLOTS];
  logic [31:0]     key_rd;
  logic [IDXW-1:0] idx;
  logic            busy;
  logic            cmp_valid;
  logic            cmp_last;
  logic [IDXW-1:0] cmp_idx;
  logic            found;
  logic            free_found;
  logic            done;

  // key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (busy) begin
      key_rd <= key_mem[idx];
    end
  end

  // address walk and compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      idx        <= '0;
      cmp_valid  <= 1'b0;
      cmp_last   <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      done       <= 1'b0;
    end else begin
      cmp_valid <= busy;
      cmp_last  <= busy && (idx == LAST);
      cmp_idx   <= idx;
      done      <= cmp_valid && cmp_last;
      if (start) begin
        busy       <= 1'b1;
        idx        <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (busy) begin
          if (idx == LAST) begin
            busy <= 1'b0;
          end else begin
            idx <= idx + IDXW'(1);
          end
        end
        if (cmp_valid) begin
          if (in_use[cmp_idx] && (key_rd == id) && !found) begin
            found   <= 1'b1;
            hit_idx <= cmp_idx;
          end
          if (!in_use[cmp_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end
        end
      end
    end
  end

  assign scan.done       = done;
  assign scan.found      = found;
  assign scan.free_found = free_found;

endmodule
